@@ sv/srpg_pkg.sv @@
package srpg_pkg;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_MOVE_ABS = 3'd1,
    REQ_MOVE_REL = 3'd2,
    REQ_SET_POS  = 3'd3,
    REQ_CONST    = 3'd4,
    REQ_STOP     = 3'd5,
    REQ_STOP_NOW = 3'd6,
    REQ_NONE     = 3'd7
  } req_e;

  localparam logic [1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [1:0] CFG_ACCEL     = 2'd1;
  localparam logic [1:0] CFG_FIRST_IV  = 2'd2;
  localparam logic [1:0] CFG_MIN_IV    = 2'd3;

  localparam int unsigned DIV_W    = 64;
  localparam logic [23:0] IV_MAX   = 24'hFFFFFF;
  localparam logic [31:0] Q_MAX    = 32'hFFFFFFFF;
  localparam logic [31:0] RAMP_MAX = 32'h7FFFFFFF;
  localparam logic [31:0] US_PER_S = 32'd1000000;

endpackage

@@ sv/stepper_ramp_pulse_generator_top.sv @@
// Step/direction generator with trapezoidal ramp on one shared serial divider.
// Items that need a new interval may wait on the divider: constant-speed requests,
// steps, moves and stops. Each 64-bit divide holds the FSM until it completes.
// Throughput: one item at a time; s_axis_tready is high only in idle.
// Reset: asynchronous active low; state returns to idle, position 0, forward.
module stepper_ramp_pulse_generator_top #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned FRAC_BITS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // step_direction, position[32], moving, interval_us[24], pad
  output logic        m_axis_tuser,   // step_pulse
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned W  = srpg_pkg::DIV_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_NI, ST_STS_WAIT, ST_NI2, ST_REC_WAIT, ST_SPD_WAIT,
    ST_CONST_WAIT, ST_STOP_WAIT, ST_OUT
  } state_e;

  state_e state_q;
  logic [19:0] max_speed_q, accel_q;
  logic [31:0] first_iv_q;
  logic [27:0] min_iv_q;

  logic signed [PW-1:0] pos_q, tgt_q;
  logic signed [31:0] ramp_q;
  logic [31:0] civ_q, cspd_q;
  logic [23:0] aiv_q, el_q;
  logic dir_q, cmode_q, pulse_q, stop_move_q;
  logic [2:0] typ_q;
  logic signed [31:0] val_q;

  logic div_start;
  logic [W-1:0] div_num, div_den, div_quo;
  logic div_busy;

  srpg_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  logic [19:0] eff_spd;
  logic [27:0] eff_min;
  logic signed [PW:0] to_go;
  logic [PW:0] adist;
  logic [31:0] sts_sat;
  logic signed [PW-1:0] vpos, relpos, tmax, stop_tgt;
  logic [31:0] av;

  assign eff_spd = (max_speed_q == '0) ? 20'd1 : max_speed_q;
  assign eff_min = (min_iv_q == '0) ? 28'd1 : min_iv_q;
  assign to_go   = {tgt_q[PW-1], tgt_q} - {pos_q[PW-1], pos_q};
  assign adist   = to_go[PW] ? (PW+1)'(-to_go) : to_go;
  assign sts_sat = (div_quo > 64'(srpg_pkg::RAMP_MAX)) ? srpg_pkg::RAMP_MAX : div_quo[31:0];
  assign vpos    = PW'(val_q);
  assign relpos  = pos_q + PW'(val_q);
  assign tmax    = {1'b0, {(PW-1){1'b1}}};
  assign av      = val_q[31] ? 32'(-val_q) : val_q;
  assign stop_tgt = dir_q ? pos_q + PW'(sts_sat) + PW'(1) : pos_q - PW'(sts_sat) - PW'(1);

  function automatic logic [23:0] iv_us(input logic [31:0] cn);
    logic [31:0] us;
    us = cn >> FRAC_BITS;
    if (us > 32'(srpg_pkg::IV_MAX)) us = 32'(srpg_pkg::IV_MAX);
    if (us == '0) us = 32'd1;
    return us[23:0];
  endfunction

  // ramp decision after stopping distance is known
  logic signed [32:0] ramp_n;
  logic [63:0] sts_ext, adist_ext;
  always_comb begin
    sts_ext   = 64'(sts_sat);
    adist_ext = 64'(adist);
    ramp_n    = {ramp_q[31], ramp_q};
    if (!to_go[PW] && to_go != '0) begin
      if (ramp_q > 0) begin
        if (sts_ext >= adist_ext || !dir_q) ramp_n = -$signed({1'b0, sts_sat});
      end else if (ramp_q < 0) begin
        if (sts_ext < adist_ext && dir_q) ramp_n = -ramp_n;
      end
    end else if (to_go[PW]) begin
      if (ramp_q > 0) begin
        if (sts_ext >= adist_ext || dir_q) ramp_n = -$signed({1'b0, sts_sat});
      end else if (ramp_q < 0) begin
        if (sts_ext < adist_ext && !dir_q) ramp_n = -ramp_n;
      end
    end
  end

  logic signed [34:0] den4;
  logic [34:0] mag4;
  assign den4 = 35'(ramp_q) * 35'sd4 + 35'sd1;
  assign mag4 = den4[34] ? 35'(-den4) : den4;
  logic [32:0] cn_rec;
  logic [31:0] cn_clamp;
  always_comb begin
    if (!den4[34]) cn_rec = (33'(civ_q) > div_quo[32:0]) ? 33'(civ_q) - div_quo[32:0] : '0;
    else cn_rec = (div_quo > 64'(srpg_pkg::Q_MAX) - 64'(civ_q)) ?
                  33'(srpg_pkg::Q_MAX) : 33'(civ_q) + div_quo[32:0];
    cn_clamp = (cn_rec < 33'(eff_min)) ? 32'(eff_min) : cn_rec[31:0];
  end

  // one divider shared by stopping distance, recurrence, speed and constant runs
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 64'd1;
    unique case (state_q)
      ST_NI: begin
        div_num = 64'(cspd_q) * 64'(cspd_q);
        div_den = (64'(accel_q) << 1) << (2 * FRAC_BITS);
        div_start = !cmode_q && accel_q != '0;
      end
      ST_EXEC: begin
        div_num = 64'(cspd_q) * 64'(cspd_q);
        div_den = (64'(accel_q) << 1) << (2 * FRAC_BITS);
        div_start = (typ_q == srpg_pkg::REQ_STOP) && cspd_q != '0 && accel_q != '0;
        if (typ_q == srpg_pkg::REQ_CONST) begin
          div_num = 64'(srpg_pkg::US_PER_S) << FRAC_BITS;
          div_den = 64'((av > 32'(eff_spd)) ? 32'(eff_spd) : av);
          div_start = val_q != '0;
        end
      end
      ST_NI2: begin
        div_num = 64'(civ_q) << 1;
        div_den = 64'(mag4);
        div_start = 1'b1;
      end
      ST_REC_WAIT: begin
        // speed from the new interval, launched as the recurrence divide ends
        div_num = 64'(srpg_pkg::US_PER_S) << (2 * FRAC_BITS);
        div_den = stop_move_q ? 64'((first_iv_q == '0) ? 32'd1 : first_iv_q)
                              : 64'(cn_clamp);
        div_start = !div_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      max_speed_q <= 20'd1000; accel_q <= '0;
      first_iv_q <= 32'd256000; min_iv_q <= 28'd256000;
      pos_q <= '0; tgt_q <= '0; ramp_q <= '0; civ_q <= '0; cspd_q <= '0;
      aiv_q <= '0; el_q <= '0; dir_q <= 1'b1; cmode_q <= 1'b0;
      pulse_q <= 1'b0; stop_move_q <= 1'b0; typ_q <= '0; val_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srpg_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_data_i[19:0];
          srpg_pkg::CFG_ACCEL:     accel_q     <= cfg_data_i[19:0];
          srpg_pkg::CFG_FIRST_IV:  first_iv_q  <= cfg_data_i;
          srpg_pkg::CFG_MIN_IV:    min_iv_q    <= cfg_data_i[27:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid) begin
          typ_q <= s_axis_tuser; val_q <= s_axis_tdata;
          pulse_q <= 1'b0; stop_move_q <= 1'b0;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          case (typ_q) inside
            srpg_pkg::REQ_TICK: begin
              // idle: no interval yet, the elapsed count keeps running
              if (aiv_q == '0) begin
                if (el_q < srpg_pkg::IV_MAX) el_q <= el_q + 1'b1;
                state_q <= ST_NI;
              end else if (el_q == srpg_pkg::IV_MAX || el_q + 24'd1 >= aiv_q) begin
                pulse_q <= 1'b1; el_q <= '0;
                pos_q <= dir_q ? pos_q + 1'b1 : pos_q - 1'b1;
                state_q <= ST_NI;
              end else begin
                el_q <= el_q + 1'b1;
                state_q <= ST_OUT;
              end
            end
            srpg_pkg::REQ_MOVE_ABS, srpg_pkg::REQ_MOVE_REL: begin
              if (!(tgt_q == ((typ_q == srpg_pkg::REQ_MOVE_ABS) ? vpos : relpos) && !cmode_q))
              begin
                cmode_q <= 1'b0;
                tgt_q <= (typ_q == srpg_pkg::REQ_MOVE_ABS) ? vpos : relpos;
                state_q <= ST_NI;
              end else begin
                state_q <= ST_OUT;
              end
            end
            srpg_pkg::REQ_SET_POS: begin
              pos_q <= vpos; tgt_q <= vpos; ramp_q <= '0; cspd_q <= '0;
              aiv_q <= '0; cmode_q <= 1'b0;
              state_q <= ST_OUT;
            end
            srpg_pkg::REQ_CONST: begin
              if (val_q == '0) begin
                tgt_q <= pos_q; ramp_q <= '0; cspd_q <= '0; aiv_q <= '0; cmode_q <= 1'b0;
                state_q <= ST_OUT;
              end else begin
                cmode_q <= 1'b1; dir_q <= !val_q[31];
                cspd_q <= 32'((av > 32'(eff_spd)) ? 32'(eff_spd) : av) << FRAC_BITS;
                ramp_q <= '0;
                tgt_q <= val_q[31] ? -tmax : tmax;
                state_q <= ST_CONST_WAIT;
              end
            end
            srpg_pkg::REQ_STOP: begin
              if (cspd_q == '0 || accel_q == '0) begin
                tgt_q <= pos_q; ramp_q <= '0; cspd_q <= '0; aiv_q <= '0; cmode_q <= 1'b0;
                state_q <= ST_OUT;
              end else begin
                cmode_q <= 1'b0; state_q <= ST_STOP_WAIT;
              end
            end
            srpg_pkg::REQ_STOP_NOW: begin
              tgt_q <= pos_q; ramp_q <= '0; cspd_q <= '0; aiv_q <= '0; cmode_q <= 1'b0;
              state_q <= ST_OUT;
            end
            default: state_q <= ST_OUT;
          endcase
        end
        ST_CONST_WAIT: if (!div_busy) begin
          civ_q <= (div_quo > 64'(srpg_pkg::Q_MAX)) ? srpg_pkg::Q_MAX : div_quo[31:0];
          aiv_q <= iv_us((div_quo > 64'(srpg_pkg::Q_MAX)) ? srpg_pkg::Q_MAX : div_quo[31:0]);
          state_q <= ST_OUT;
        end
        ST_STOP_WAIT: if (!div_busy) begin
          // move_to on the stopping point
          if (tgt_q != stop_tgt) begin
            tgt_q <= stop_tgt; state_q <= ST_NI;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_NI: begin
          if (cmode_q) begin
            aiv_q <= iv_us(civ_q); state_q <= ST_OUT;
          end else if (accel_q == '0) begin
            state_q <= ST_OUT;
            if (to_go == '0) begin
              aiv_q <= '0; cspd_q <= '0;
            end else begin
              dir_q <= !to_go[PW];
              cspd_q <= 32'(eff_spd) << FRAC_BITS;
              civ_q <= 32'(eff_min);
              aiv_q <= iv_us(32'(eff_min));
            end
          end else begin
            state_q <= ST_STS_WAIT;
          end
        end
        ST_STS_WAIT: if (!div_busy) begin
          if (to_go == '0 && sts_sat <= 32'd1) begin
            aiv_q <= '0; cspd_q <= '0; ramp_q <= '0; state_q <= ST_OUT;
          end else if (ramp_n == '0) begin
            civ_q <= first_iv_q; dir_q <= !to_go[PW] && to_go != '0;
            ramp_q <= 32'sd1;
            state_q <= ST_REC_WAIT;
            stop_move_q <= 1'b1;
          end else begin
            ramp_q <= ramp_n[31:0];
            state_q <= ST_NI2;
          end
        end
        ST_NI2: state_q <= ST_REC_WAIT;
        ST_REC_WAIT: if (!div_busy) begin
          if (!stop_move_q) begin
            civ_q <= cn_clamp;
            if (ramp_q < $signed(srpg_pkg::RAMP_MAX)) ramp_q <= ramp_q + 1'b1;
          end
          stop_move_q <= 1'b0;
          state_q <= ST_SPD_WAIT;
        end
        ST_SPD_WAIT: if (!div_busy) begin
          aiv_q <= iv_us(civ_q);
          cspd_q <= (div_quo > 64'(srpg_pkg::Q_MAX)) ? srpg_pkg::Q_MAX : div_quo[31:0];
          state_q <= ST_OUT;
        end
        ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = state_q == ST_OUT;
  assign m_axis_tuser  = pulse_q;
  assign m_axis_tdata  = {6'd0, aiv_q, (aiv_q != '0 || pos_q != tgt_q),
                          32'(pos_q), dir_q};
endmodule

@@ sv/srpg_div.sv @@
// Restoring divider, one quotient bit per cycle.
module srpg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [srpg_pkg::DIV_W-1:0]   num_i,
  input  logic [srpg_pkg::DIV_W-1:0]   den_i,
  output logic                         busy_o,
  output logic [srpg_pkg::DIV_W-1:0]   quo_o
);
  localparam int unsigned W  = srpg_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  num_q, den_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    trial;
  logic          busy_q;

  assign trial = {rem_q, num_q[W-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        num_q <= {num_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], num_q[W-1]};
        num_q <= {num_q[W-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q;
endmodule

@@ tb/stepper_ramp_pulse_generator_top_tb.sv @@
module stepper_ramp_pulse_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Result fields as carried on the master side
  typedef struct packed {
    logic        pulse;
    logic        dir;
    logic [31:0] pos;
    logic        moving;
    logic [23:0] iv_us;
  } step_res_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
  } step_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = srpg_pkg::REQ_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = srpg_pkg::CFG_MAX_SPEED;
  logic [31:0] cfg_data_i = '0;

  stepper_ramp_pulse_generator_top dut (.*);

  always #6 clk_i = ~clk_i;

  // Predictor state, mirrors the block after each accepted transfer
  logic [31:0] p_max_sp, p_accel, p_first_iv, p_min_iv;
  longint      p_pos, p_tgt;
  int          p_ramp;
  logic [31:0] p_iv_q8, p_sp_q8;
  logic [23:0] p_act_us, p_elap;
  bit          p_dir, p_const;

  step_req_t   pending_q[$];
  step_res_t   expected_q[$];
  int          mism = 0;
  longint      cycles = 0;
  bit          hold_rx = 1'b0;
  bit          feed_en = 1'b0;
  int          burst = 0, gap = 0;

  function automatic longint wrap32(longint x);
    return longint'(int'(x[31:0]));
  endfunction

  function automatic logic [31:0] eff_max();
    return (p_max_sp == 0) ? 32'd1 : p_max_sp;
  endfunction

  function automatic logic [31:0] eff_min();
    return (p_min_iv == 0) ? 32'd1 : p_min_iv;
  endfunction

  task automatic load_iv(logic [31:0] cn);
    logic [31:0] us;
    us = cn >> 8;
    if (us > 32'hFFFFFF) us = 32'hFFFFFF;
    if (us == 0) us = 1;
    p_act_us = us[23:0];
  endtask

  function automatic logic [31:0] speed_from_iv(logic [31:0] cn);
    logic [63:0] q;
    q = (64'd1000000 << 16) / ((cn == 0) ? 64'd1 : 64'(cn));
    return (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
  endfunction

  function automatic longint brake_steps();
    logic [63:0] sp, den, q;
    sp  = 64'(p_sp_q8);
    den = (64'd2 * 64'(p_accel)) << 16;
    q   = (sp * sp) / den;
    return (q > 64'h7FFFFFFF) ? 64'h7FFFFFFF : longint'(q);
  endfunction

  // Next interval after a step or when a move starts
  task automatic plan_interval();
    longint to_go, sts, ramp, den;
    logic [63:0] mag, cn, delta;
    to_go = p_tgt - p_pos;
    if (p_const) begin
      load_iv(p_iv_q8);
      return;
    end
    if (p_accel == 0) begin
      if (to_go == 0) begin
        p_act_us = 0; p_sp_q8 = 0;
        return;
      end
      p_dir = to_go > 0;
      p_sp_q8 = eff_max() << 8;
      p_iv_q8 = eff_min();
      load_iv(p_iv_q8);
      return;
    end
    sts = brake_steps();
    if (to_go == 0 && sts <= 1) begin
      p_act_us = 0; p_sp_q8 = 0; p_ramp = 0;
      return;
    end
    ramp = p_ramp;
    if (to_go > 0) begin
      if (ramp > 0) begin
        if (sts >= to_go || !p_dir) ramp = -sts;
      end else if (ramp < 0) begin
        if (sts < to_go && p_dir) ramp = -ramp;
      end
    end else if (to_go < 0) begin
      if (ramp > 0) begin
        if (sts >= -to_go || p_dir) ramp = -sts;
      end else if (ramp < 0) begin
        if (sts < -to_go && !p_dir) ramp = -ramp;
      end
    end
    if (ramp == 0) begin
      p_iv_q8 = p_first_iv;
      p_dir = to_go > 0;
    end else begin
      den = 4 * ramp + 1;
      mag = (den < 0) ? 64'(-den) : 64'(den);
      cn = 64'(p_iv_q8);
      delta = (2 * cn) / mag;
      if (den > 0) cn = (cn > delta) ? cn - delta : 64'd0;
      else begin
        cn = cn + delta;
        if (cn > 64'hFFFFFFFF) cn = 64'hFFFFFFFF;
      end
      if (cn < 64'(eff_min())) cn = 64'(eff_min());
      p_iv_q8 = cn[31:0];
    end
    if (ramp < 2147483647) ramp++;
    p_ramp = int'(ramp);
    load_iv(p_iv_q8);
    p_sp_q8 = speed_from_iv(p_iv_q8);
  endtask

  task automatic halt_at_once();
    p_tgt = p_pos; p_ramp = 0; p_sp_q8 = 0; p_act_us = 0; p_const = 0;
  endtask

  task automatic head_for(longint dest);
    if (p_tgt == dest && !p_const) return;
    p_const = 0;
    p_tgt = dest;
    plan_interval();
  endtask

  task automatic predict_step(step_req_t rq);
    longint v, n;
    logic [63:0] sp, cn;
    step_res_t r;
    bit pulse;
    pulse = 0;
    v = longint'($signed(rq.value));
    case (srpg_pkg::req_e'(rq.kind))
      srpg_pkg::REQ_TICK: begin
        if (p_elap < 24'hFFFFFF) p_elap++;
        if (p_act_us == 0) plan_interval();
        if (p_act_us != 0 && p_elap >= p_act_us) begin
          pulse = 1;
          p_elap = 0;
          p_pos = wrap32(p_pos + (p_dir ? 1 : -1));
          plan_interval();
        end
      end
      srpg_pkg::REQ_MOVE_ABS: head_for(wrap32(v));
      srpg_pkg::REQ_MOVE_REL: head_for(wrap32(p_pos + v));
      srpg_pkg::REQ_SET_POS: begin
        p_pos = wrap32(v);
        p_tgt = p_pos;
        p_ramp = 0; p_sp_q8 = 0; p_act_us = 0; p_const = 0;
      end
      srpg_pkg::REQ_CONST: begin
        if (v == 0) halt_at_once();
        else begin
          sp = (v < 0) ? 64'(-v) : 64'(v);
          if (sp > 64'(eff_max())) sp = 64'(eff_max());
          p_const = 1;
          p_dir = v > 0;
          p_sp_q8 = 32'(sp << 8);
          p_ramp = 0;
          cn = (64'd1000000 << 8) / sp;
          p_iv_q8 = (cn > 64'hFFFFFFFF) ? 32'hFFFFFFFF : cn[31:0];
          load_iv(p_iv_q8);
          p_tgt = p_dir ? 64'sd2147483647 : -64'sd2147483647;
        end
      end
      srpg_pkg::REQ_STOP: begin
        if (p_sp_q8 == 0) halt_at_once();
        else begin
          p_const = 0;
          if (p_accel == 0) halt_at_once();
          else begin
            n = brake_steps() + 1;
            head_for(wrap32(p_dir ? p_pos + n : p_pos - n));
          end
        end
      end
      srpg_pkg::REQ_STOP_NOW: halt_at_once();
      default: ;
    endcase
    r.pulse  = pulse;
    r.dir    = p_dir;
    r.pos    = p_pos[31:0];
    r.moving = (p_act_us != 0 || p_pos != p_tgt);
    r.iv_us  = p_act_us;
    expected_q.push_back(r);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      srpg_pkg::CFG_MAX_SPEED: p_max_sp   = val & 32'hFFFFF;
      srpg_pkg::CFG_ACCEL:     p_accel    = val & 32'hFFFFF;
      srpg_pkg::CFG_FIRST_IV:  p_first_iv = val;
      default:                 p_min_iv   = val & 32'hFFFFFFF;
    endcase
  endtask

  // Let the queue drain and the block fall quiet before touching registers
  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic push(srpg_pkg::req_e k, logic [31:0] v);
    step_req_t rq;
    rq.kind = k;
    rq.value = v;
    pending_q.push_back(rq);
  endtask

  // Random move, constant-speed, stop or arbitrary request, then ticks to carry it out
  task automatic push_move_run(int ticks);
    int sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0: push(srpg_pkg::REQ_MOVE_ABS, $urandom_range(0, 60) - 30);
      1, 2: push(srpg_pkg::REQ_MOVE_REL, $urandom_range(0, 40) - 20);
      3: push(srpg_pkg::REQ_CONST, $urandom_range(0, 4000) - 2000);
      4: push(srpg_pkg::REQ_STOP, $urandom);
      default: push(srpg_pkg::req_e'($urandom_range(0, 7)), $urandom);
    endcase
    repeat (ticks) push(srpg_pkg::REQ_TICK, $urandom);
  endtask

  // Sender: bursts and gaps
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (s_axis_tvalid && s_axis_tready) void'(pending_q.pop_front());
    if (s_axis_tvalid && !s_axis_tready) begin
      // hold the offered item
    end else if (feed_en && pending_q.size() > 0 && (burst > 0 || gap == 0)) begin
      step_req_t nx;
      nx = pending_q[0];
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= nx.value;
      s_axis_tuser  <= nx.kind;
      if (burst > 0) burst <= burst - 1;
      else begin
        burst <= $urandom_range(0, 20);
        gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
      if (gap > 0) gap <= gap - 1;
    end
  end

  // Predictions are made at acceptance, in transfer order
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      step_req_t rq;
      rq.kind = s_axis_tuser;
      rq.value = s_axis_tdata;
      predict_step(rq);
    end
  end

  // Receiver stall pattern, with forced long hold-offs
  always @(posedge clk_i) begin
    if (hold_rx) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 9) < 7) || (cycles[11:9] == 3'd0);
  end

  // Monitor: compare against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      step_res_t got, exp_r;
      got.dir    = m_axis_tdata[0];
      got.pos    = m_axis_tdata[32:1];
      got.moving = m_axis_tdata[33];
      got.iv_us  = m_axis_tdata[57:34];
      got.pulse  = m_axis_tuser;
      if (expected_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result transfer %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mism++;
          if (mism <= 10) begin
            $display("mismatch: exp pulse %0b dir %0b pos %0d mov %0b iv %0d",
                     exp_r.pulse, exp_r.dir, $signed(exp_r.pos), exp_r.moving,
                     exp_r.iv_us);
            $display("          got pulse %0b dir %0b pos %0d mov %0b iv %0d",
                     got.pulse, got.dir, $signed(got.pos), got.moving, got.iv_us);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycles > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    p_max_sp = 1000; p_accel = 0; p_first_iv = 256000; p_min_iv = 256000;
    p_pos = 0; p_tgt = 0; p_ramp = 0; p_iv_q8 = 0; p_sp_q8 = 0;
    p_act_us = 0; p_elap = 0; p_dir = 1; p_const = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    feed_en = 1'b1;

    // Directed: reset settings, no ramp, every request and edge value
    push(srpg_pkg::REQ_TICK, 0);
    push(srpg_pkg::REQ_MOVE_ABS, 3);
    repeat (6) push(srpg_pkg::REQ_TICK, 0);
    push(srpg_pkg::REQ_NONE, 32'hFFFFFFFF);
    push(srpg_pkg::REQ_SET_POS, 32'h7FFFFFFF);
    push(srpg_pkg::REQ_MOVE_REL, 2);
    repeat (4) push(srpg_pkg::REQ_TICK, 32'hFFFFFFFF);
    push(srpg_pkg::REQ_SET_POS, 32'h80000001);
    push(srpg_pkg::REQ_CONST, 32'h80000001);
    repeat (3) push(srpg_pkg::REQ_TICK, 0);
    push(srpg_pkg::REQ_STOP, 0);
    push(srpg_pkg::REQ_CONST, 0);
    push(srpg_pkg::REQ_STOP_NOW, 0);
    push(srpg_pkg::REQ_MOVE_ABS, 32'h7FFFFFFF);
    push(srpg_pkg::REQ_STOP, 0);
    drain();

    // Extremes: zero speed and minimum interval, largest first interval and acceleration, tiny intervals
    set_reg(srpg_pkg::CFG_MAX_SPEED, 0);
    set_reg(srpg_pkg::CFG_MIN_IV, 0);
    set_reg(srpg_pkg::CFG_FIRST_IV, 32'hFFFFFFFF);
    set_reg(srpg_pkg::CFG_ACCEL, 32'hFFFFF);
    push(srpg_pkg::REQ_MOVE_REL, 4);
    repeat (10) push(srpg_pkg::REQ_TICK, 0);
    push(srpg_pkg::REQ_CONST, 5);
    repeat (4) push(srpg_pkg::REQ_TICK, 0);
    push(srpg_pkg::REQ_STOP, 0);
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_reg(srpg_pkg::CFG_MAX_SPEED, 32'hFFFFF); set_reg(srpg_pkg::CFG_ACCEL, 0);
          set_reg(srpg_pkg::CFG_MIN_IV, 256); set_reg(srpg_pkg::CFG_FIRST_IV, 256);
        end
        1: begin
          set_reg(srpg_pkg::CFG_MAX_SPEED, 100000); set_reg(srpg_pkg::CFG_ACCEL, 200000);
          set_reg(srpg_pkg::CFG_MIN_IV, 1024); set_reg(srpg_pkg::CFG_FIRST_IV, 2048);
        end
        2: begin
          set_reg(srpg_pkg::CFG_MAX_SPEED, 50000); set_reg(srpg_pkg::CFG_ACCEL, 1000000);
          set_reg(srpg_pkg::CFG_MIN_IV, 5120); set_reg(srpg_pkg::CFG_FIRST_IV, 1280);
        end
        3: begin
          set_reg(srpg_pkg::CFG_MAX_SPEED, 1); set_reg(srpg_pkg::CFG_ACCEL, 1);
          set_reg(srpg_pkg::CFG_MIN_IV, 32'hFFFFFFF); set_reg(srpg_pkg::CFG_FIRST_IV, 768);
        end
        4: begin
          set_reg(srpg_pkg::CFG_MAX_SPEED, $urandom_range(1, 1000000));
          set_reg(srpg_pkg::CFG_ACCEL, $urandom_range(1000, 1000000));
          set_reg(srpg_pkg::CFG_MIN_IV, $urandom_range(256, 4000));
          set_reg(srpg_pkg::CFG_FIRST_IV, $urandom_range(256, 8000));
        end
        default: begin
          set_reg(srpg_pkg::CFG_ACCEL, 0); set_reg(srpg_pkg::CFG_MIN_IV, 300);
        end
      endcase
      for (int k = 0; k < 15; k++) push_move_run($urandom_range(5, 35));
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        hold_rx = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      if (ph == 4) begin
        // odd values on every input bit
        repeat (30) push(srpg_pkg::req_e'($urandom_range(0, 7)), $urandom);
        push(srpg_pkg::REQ_SET_POS, 0);
      end
      drain();
    end

    while (expected_q.size() != 0 && cycles < 3000000) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (mism == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
